// File: rtl/radix_trie_insert_lookup_assert.svh
// assertion macros for the radix trie key-set engine
// expects i_clk and i_rst_n in the scope of the including module
`ifndef RADIX_TRIE_INSERT_LOOKUP_ASSERT_SVH
`define RADIX_TRIE_INSERT_LOOKUP_ASSERT_SVH

// same-cycle implication
`define RTIL_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("radix trie: same-cycle check failed");

// next-cycle implication
`define RTIL_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("radix trie: next-cycle check failed");

`endif

// File: rtl/rtil_pkg.sv
// constants, types and helpers of the radix trie key-set engine
// no dependencies
`timescale 1ns / 1ps

package rtil_pkg;

    localparam int NODE_COUNT  = 4096;
    localparam int LEVEL_BITS  = 3;
    localparam int KEY_BITS    = 63;
    localparam int SLOT_W      = 64;
    localparam int SLOTS       = 1 << LEVEL_BITS;
    localparam int ROW_W       = SLOTS * SLOT_W;
    localparam int LEVEL_COUNT = (KEY_BITS + LEVEL_BITS - 1) / LEVEL_BITS;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int CNT_W       = $clog2(NODE_COUNT + 1);
    localparam int DEPTH_W     = $clog2(LEVEL_COUNT + 1);

    // result codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_DUP    = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // request codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_COUNT = 7'b0010000,
        S_PUSH  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    // digit of a key at a trie level, top bits first, short last level padded below
    function automatic logic [LEVEL_BITS-1:0] digit_at(input logic [KEY_BITS-1:0] key,
                                                      input logic [DEPTH_W-1:0] depth);
        int                  sh;
        logic [KEY_BITS-1:0] t;
        sh = KEY_BITS - (int'(depth) + 1) * LEVEL_BITS;
        if (sh >= 0) begin
            t = key >> sh;
        end else begin
            t = key << (-sh);
        end
        return t[LEVEL_BITS-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] get_slot(input logic [ROW_W-1:0] row,
                                                   input logic [LEVEL_BITS-1:0] idx);
        return row[SLOT_W*int'(idx) +: SLOT_W];
    endfunction

    function automatic logic [ROW_W-1:0] set_slot(input logic [ROW_W-1:0] row,
                                                  input logic [LEVEL_BITS-1:0] idx,
                                                  input logic [SLOT_W-1:0] val);
        logic [ROW_W-1:0] r;
        r = row;
        r[SLOT_W*int'(idx) +: SLOT_W] = val;
        return r;
    endfunction

    // child pointer: tag bit on top, node index below
    function automatic logic [SLOT_W-1:0] make_ptr(input logic [NODE_W-1:0] node);
        return {1'b1, {(SLOT_W-1-NODE_W){1'b0}}, node};
    endfunction

endpackage

// File: rtl/radix_trie_insert_lookup.sv
// radix trie key-set engine: insert and lookup of 63-bit keys in an 8-ary trie
// depends on rtil_pkg and radix_trie_insert_lookup_assert.svh
`timescale 1ns / 1ps
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  request | i_valid o_stall i_action i_key       | in
//  result  | o_valid i_stall o_found o_status     | out
//          | o_nodes_in_use                       |
//
//  one word in, one word out; a lookup reads a node row, then decodes its slot, at each
//  trie level that it descends, over up to 21 levels
//  an insert that collides walks the shared digits one a cycle, then writes one fresh
//  node row a cycle; one node memory access per state sets these rates
//  after reset the S_INIT state clears the root row before the first word is taken
//  a result waiting on a stalled output does not block the next request; only the end
//  of that request waits for the output register to free up

module radix_trie_insert_lookup (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_action,
    input  logic [63:0]                i_key,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_found,
    output logic [1:0]                 o_status,
    output logic [rtil_pkg::CNT_W-1:0] o_nodes_in_use
);
    import rtil_pkg::*;

    // node memory: one row of eight slots per node
    logic [ROW_W-1:0] mem [NODE_COUNT];
    logic [ROW_W-1:0] r_rd_row;

    // sequencer state
    t_state             r_state,     n_state;
    logic [CNT_W-1:0]   r_next_free, n_next_free;
    logic [63:0]        r_key,       n_key;
    logic               r_action,    n_action;
    logic [NODE_W-1:0]  r_node,      n_node;    // node being descended
    logic [DEPTH_W-1:0] r_depth,     n_depth;
    logic [SLOT_W-1:0]  r_old,       n_old;     // colliding stored key
    logic [DEPTH_W-1:0] r_nd,        n_nd;      // push-down level
    logic [DEPTH_W-1:0] r_need,      n_need;    // nodes the push-down needs
    logic [NODE_W-1:0]  r_cur,       n_cur;     // node being filled by the push-down
    logic               r_res_found, n_res_found;
    logic [1:0]         r_res_status, n_res_status;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               r_found,     n_found;
    logic [1:0]         r_status,    n_status;
    logic [CNT_W-1:0]   r_nodes,     n_nodes;

    // memory port controls
    logic               w_we, w_re;
    logic [NODE_W-1:0]  w_waddr;
    logic [ROW_W-1:0]   w_wdata;

    logic                  w_accept;
    logic                  w_out_free;
    logic [LEVEL_BITS-1:0] w_dig;
    logic [SLOT_W-1:0]     w_slot;
    logic                  w_ptr_ok;
    logic [LEVEL_BITS-1:0] w_dig_old, w_dig_new;
    logic                  w_nd_live;
    logic [CNT_W:0]        w_demand;
    logic                  w_wr_state;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    // slot picked by the current digit in the row just read
    assign w_dig  = digit_at(r_key[KEY_BITS-1:0], r_depth);
    assign w_slot = get_slot(r_rd_row, w_dig);
    // a pointer is followed only into an allocated node
    assign w_ptr_ok = (w_slot[SLOT_W-2:CNT_W] == '0) && (w_slot[CNT_W-1:0] < r_next_free);

    // push-down digits of both keys
    assign w_dig_old = digit_at(r_old[KEY_BITS-1:0], r_nd);
    assign w_dig_new = digit_at(r_key[KEY_BITS-1:0], r_nd);
    assign w_nd_live = (r_nd < DEPTH_W'(LEVEL_COUNT));
    assign w_demand  = {1'b0, r_next_free} + (CNT_W+1)'(r_need);

    // states that may write the node memory
    assign w_wr_state = (r_state == S_INIT) || (r_state == S_EVAL) ||
                        (r_state == S_COUNT) || (r_state == S_PUSH);

    always_comb begin
        n_state      = r_state;
        n_next_free  = r_next_free;
        n_key        = r_key;
        n_action     = r_action;
        n_node       = r_node;
        n_depth      = r_depth;
        n_old        = r_old;
        n_nd         = r_nd;
        n_need       = r_need;
        n_cur        = r_cur;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_stall;
        n_found      = r_found;
        n_status     = r_status;
        n_nodes      = r_nodes;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = r_node;
        w_wdata      = r_rd_row;

        case (r_state)
            S_INIT: begin
                // clear the root row
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '0;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_key        = i_key;
                    n_action     = i_action;
                    n_node       = '0;
                    n_depth      = '0;
                    n_res_found  = 1'b0;
                    n_res_status = ST_DONE;
                    if (i_key[63]) begin
                        n_res_status = ST_REJECT;
                        n_state      = S_FIN;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                w_re    = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_FIN;
                if (w_slot == '0) begin
                    // empty slot: an insert stores the key here
                    if (r_action == ACT_INSERT) begin
                        w_we    = 1'b1;
                        w_wdata = set_slot(r_rd_row, w_dig, r_key);
                    end
                end else if (w_slot[SLOT_W-1]) begin
                    if (w_ptr_ok && (r_depth != DEPTH_W'(LEVEL_COUNT - 1))) begin
                        n_node  = w_slot[NODE_W-1:0];
                        n_depth = r_depth + 1'b1;
                        n_state = S_RD;
                    end
                end else if (r_action == ACT_LOOKUP) begin
                    n_res_found = (w_slot == r_key);
                end else if (w_slot == r_key) begin
                    n_res_status = ST_DUP;
                end else begin
                    // collision: count the shared digits below this level
                    n_old   = w_slot;
                    n_nd    = r_depth + 1'b1;
                    n_need  = DEPTH_W'(1);
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (w_nd_live && (w_dig_old == w_dig_new)) begin
                    n_nd   = r_nd + 1'b1;
                    n_need = r_need + 1'b1;
                end else if (w_demand > (CNT_W+1)'(NODE_COUNT)) begin
                    n_res_status = ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    // parent slot now points at the first fresh node
                    w_we        = 1'b1;
                    w_wdata     = set_slot(r_rd_row, w_dig, make_ptr(r_next_free[NODE_W-1:0]));
                    n_cur       = r_next_free[NODE_W-1:0];
                    n_next_free = r_next_free + 1'b1;
                    n_nd        = r_depth + 1'b1;
                    n_state     = S_PUSH;
                end
            end
            S_PUSH: begin
                // every fresh row is written whole, which clears it
                w_we    = 1'b1;
                w_waddr = r_cur;
                w_wdata = '0;
                n_state = S_FIN;
                if (w_nd_live) begin
                    if (w_dig_old != w_dig_new) begin
                        w_wdata = set_slot(set_slot('0, w_dig_old, r_old), w_dig_new, r_key);
                    end else begin
                        w_wdata     = set_slot('0, w_dig_old, make_ptr(r_next_free[NODE_W-1:0]));
                        n_cur       = r_next_free[NODE_W-1:0];
                        n_next_free = r_next_free + 1'b1;
                        n_nd        = r_nd + 1'b1;
                        n_state     = S_PUSH;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_found     = r_res_found;
                    n_status    = r_res_status;
                    n_nodes     = r_next_free;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_row <= mem[r_node];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_next_free <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_action     <= n_action;
        r_node       <= n_node;
        r_depth      <= n_depth;
        r_old        <= n_old;
        r_nd         <= n_nd;
        r_need       <= n_need;
        r_cur        <= n_cur;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_found      <= n_found;
        r_status     <= n_status;
        r_nodes      <= n_nodes;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_found        = r_found;
    assign o_status       = r_status;
    assign o_nodes_in_use = r_nodes;

    `include "radix_trie_insert_lookup_assert.svh"

    `RTIL_ASSERT_IMPL(a_pool_bound, 1'b1, r_next_free <= CNT_W'(NODE_COUNT))
    `RTIL_ASSERT_IMPL(a_write_states, w_we, w_wr_state)
    `RTIL_ASSERT_NEXT(a_accept_busy, w_accept, r_state != S_IDLE)
    `RTIL_ASSERT_NEXT(a_result_shown, (r_state == S_FIN) && w_out_free, o_valid)
endmodule

// File: dv/testbench.sv
// self-checking testbench for the radix trie key-set engine (insert and lookup words)
// depends on rtil_pkg and the radix_trie_insert_lookup rtl; a mirror of the trie predicts
// every result word, with random idling on both channels
`timescale 1ns / 1ps

module testbench;

    import rtil_pkg::*;

    localparam int ITEM_TARGET = 1250;   // stimulus stops here
    localparam int QUIET_FROM  = 1100;   // no idling on either side from this word on
    localparam int LONG_HOLD   = 400;    // receiver hold-off, in cycles
    localparam int SLOT_TOTAL  = NODE_COUNT * SLOTS;

    typedef struct packed {
        logic             found;
        logic [1:0]       status;
        logic [CNT_W-1:0] nodes;
    } t_trie_answer;

    // mirror of the trie contents plus the queue of result words still owed by the block
    class trie_mirror;
        logic [63:0]  slot_mem [SLOT_TOTAL];
        int           next_free;
        t_trie_answer awaited[$];
        int           fail_count = 0;
        int           n_checked  = 0;
        int           n_stored   = 0;
        int           n_dup      = 0;
        int           n_reject   = 0;
        int           n_full     = 0;
        int           n_hits     = 0;

        function new();
            foreach (slot_mem[i]) slot_mem[i] = '0;
            next_free = 1;
        endfunction

        // level digit, top key bits first; a short last level is padded below
        function logic [LEVEL_BITS-1:0] level_digit(logic [63:0] key, int level);
            int          sh;
            logic [63:0] t;
            sh = KEY_BITS - (level + 1) * LEVEL_BITS;
            t  = (sh >= 0) ? (key >> sh) : (key << (-sh));
            return t[LEVEL_BITS-1:0];
        endfunction

        function logic walk_lookup(logic [63:0] key);
            int          node;
            logic [63:0] s;
            node = 0;
            for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
                s = slot_mem[node * SLOTS + int'(level_digit(key, lvl))];
                if (s == '0) return 1'b0;
                if (!s[63]) return s == key;
                if (s[62:0] >= next_free) return 1'b0;
                node = int'(s[62:0]);
            end
            return 1'b0;
        endfunction

        function logic [1:0] walk_insert(logic [63:0] key);
            int          node, addr, need, nd, cur;
            logic [63:0] s;
            node = 0;
            for (int lvl = 0; lvl < LEVEL_COUNT; lvl++) begin
                addr = node * SLOTS + int'(level_digit(key, lvl));
                s    = slot_mem[addr];
                if (s == '0) begin
                    slot_mem[addr] = key;
                    return ST_DONE;
                end
                if (s[63]) begin
                    if (s[62:0] >= next_free) return ST_DONE;
                    node = int'(s[62:0]);
                    continue;
                end
                if (s == key) return ST_DUP;
                // count the fresh nodes the push-down needs before touching anything
                need = 1;
                nd   = lvl + 1;
                while (nd < LEVEL_COUNT && level_digit(s, nd) == level_digit(key, nd)) begin
                    need++;
                    nd++;
                end
                if (next_free + need > NODE_COUNT) return ST_FULL;
                cur = next_free++;
                slot_mem[addr] = {1'b1, 63'(cur)};
                for (nd = lvl + 1; nd < LEVEL_COUNT; nd++) begin
                    if (level_digit(s, nd) != level_digit(key, nd)) begin
                        slot_mem[cur * SLOTS + int'(level_digit(s, nd))]   = s;
                        slot_mem[cur * SLOTS + int'(level_digit(key, nd))] = key;
                        return ST_DONE;
                    end
                    slot_mem[cur * SLOTS + int'(level_digit(s, nd))] = {1'b1, 63'(next_free)};
                    cur = next_free++;
                end
                return ST_DONE;
            end
            return ST_DONE;
        endfunction

        function void note_request(logic act, logic [63:0] key);
            t_trie_answer a;
            a.found = 1'b0;
            if (key[63]) begin
                a.status = ST_REJECT;
            end else if (act == ACT_INSERT) begin
                a.status = walk_insert(key);
            end else begin
                a.found  = walk_lookup(key);
                a.status = ST_DONE;
            end
            a.nodes = CNT_W'(next_free);
            awaited = {awaited, a};
        endfunction

        function void check_result(logic found, logic [1:0] status, logic [CNT_W-1:0] nodes);
            t_trie_answer want;
            if (awaited.size() == 0) begin
                $error("result word with no request outstanding");
                fail_count++;
                return;
            end
            want = awaited.pop_front();
            n_checked++;
            if (found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, found);
                fail_count++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                fail_count++;
            end
            if (nodes !== want.nodes) begin
                $error("nodes_in_use: expected %0d, got %0d", want.nodes, nodes);
                fail_count++;
            end
            case (want.status)
                ST_DUP:    n_dup++;
                ST_REJECT: n_reject++;
                ST_FULL:   n_full++;
                default:   n_stored++;
            endcase
            if (want.found) n_hits++;
        endfunction
    endclass

    // every block input holds a known value from time zero
    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 i_valid  = 1'b0;
    logic                 i_action = ACT_INSERT;
    logic [63:0]          i_key    = '0;
    logic                 i_stall  = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_found;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_nodes_in_use;

    trie_mirror  mirror;
    logic [63:0] known_keys[$];     // keys offered for insert, reused for hits and duplicates
    int          items_sent   = 0;
    logic        hold_request = 1'b0;
    int          long_holds   = 0;

    radix_trie_insert_lookup dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_key          (i_key),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_nodes_in_use (o_nodes_in_use)
    );

    always #4 i_clk = ~i_clk;

    // offer one request word, with an occasional idle burst ahead of it; the payload
    // stays put until the block takes it, and the mirror is updated at that edge
    task automatic offer_word(input logic act, input logic [63:0] key);
        if (items_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_key    <= key;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        mirror.note_request(act, key);
        items_sent++;
    endtask

    // sender pause: drop valid and hold off until every owed result word is back
    task automatic wait_for_answers();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.awaited.size() != 0);
    endtask

    function automatic logic [63:0] any_known_key();
        if (known_keys.size() == 0) return {1'b0, 31'($urandom), $urandom};
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    // mixed traffic: fresh keys, hits, duplicates, near neighbours of stored keys
    // (which push down deep), tiny keys around zero and rejected keys
    task automatic random_word();
        logic        act;
        logic [63:0] k;
        act = $urandom_range(0, 1) ? ACT_LOOKUP : ACT_INSERT;
        case ($urandom_range(0, 11))
            0:       k = {1'b1, 31'($urandom), $urandom};
            1:       k = 64'($urandom_range(0, 15));
            2, 3, 4: k = any_known_key();
            5, 6:    k = any_known_key() ^ (64'd1 << $urandom_range(0, 62));
            default: k = {1'b0, 31'($urandom), $urandom};
        endcase
        if (act == ACT_INSERT && !k[63]) known_keys = {known_keys, k};
        offer_word(act, k);
    endtask

    // receiver: checks each accepted result word, then picks the stall for the next cycle
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                mirror.check_result(o_found, o_status, o_nodes_in_use);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_request) begin
                // long hold-off so the block backs up and stalls its request side
                hold_request = 1'b0;
                hold_left    = LONG_HOLD - 1;
                long_holds++;
                i_stall <= 1'b1;
            end else if (items_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 7);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic [63:0] base, mate;
        int          tail_pairs;
        mirror = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: key zero, the largest key, rejects, a duplicate, full-depth push-downs
        offer_word(ACT_LOOKUP, 64'd0);
        offer_word(ACT_INSERT, 64'd0);
        offer_word(ACT_LOOKUP, 64'd0);
        offer_word(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        offer_word(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
        offer_word(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
        offer_word(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);
        offer_word(ACT_LOOKUP, 64'h8000_0000_0000_0000);
        offer_word(ACT_INSERT, 64'h8000_0000_0000_0000);
        // differs only in bit 0: shares every digit but the last
        offer_word(ACT_INSERT, 64'h7FFF_FFFF_FFFF_FFFE);
        offer_word(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFE);
        offer_word(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFD);
        offer_word(ACT_LOOKUP, 64'h7000_0000_0000_0000);
        // zero collides with key one and gets pushed down but is never stored
        offer_word(ACT_INSERT, 64'd1);
        offer_word(ACT_INSERT, 64'd0);
        offer_word(ACT_LOOKUP, 64'd0);
        offer_word(ACT_LOOKUP, 64'd1);
        offer_word(ACT_INSERT, 64'd1);
        offer_word(ACT_LOOKUP, 64'd2);
        offer_word(ACT_INSERT, 64'h5555_5555_5555_5555);
        offer_word(ACT_INSERT, 64'h2AAA_AAAA_AAAA_AAAA);
        offer_word(ACT_LOOKUP, 64'h2AAA_AAAA_AAAA_AAAA);
        offer_word(ACT_LOOKUP, 64'h5555_5555_5555_5554);
        known_keys = {known_keys, 64'h7FFF_FFFF_FFFF_FFFF};
        known_keys = {known_keys, 64'h7FFF_FFFF_FFFF_FFFE};
        known_keys = {known_keys, 64'd1};
        wait_for_answers();

        // mixed random traffic, with one long receiver hold-off partway through
        for (int n = 0; n < 340; n++) begin
            if (n == 120) hold_request = 1'b1;
            random_word();
        end
        wait_for_answers();

        // key pairs differing only in low bits: each pair eats a long chain of nodes,
        // so the pool runs dry; keep going a while so refusals show up
        tail_pairs = 0;
        while (tail_pairs < 40 && items_sent < QUIET_FROM - 20) begin
            base = {1'b0, 31'($urandom), $urandom};
            mate = base ^ (64'd1 << $urandom_range(0, 5));
            known_keys = {known_keys, base};
            known_keys = {known_keys, mate};
            offer_word(ACT_INSERT, base);
            offer_word(ACT_INSERT, mate);
            if ($urandom_range(0, 2) == 0) begin
                offer_word(ACT_LOOKUP, $urandom_range(0, 1) ? mate : (mate ^ 64'd8));
            end
            if (mirror.next_free > NODE_COUNT - 24) tail_pairs++;
        end
        wait_for_answers();

        // mixed traffic again against a nearly full trie; the last stretch runs without idling
        while (items_sent < ITEM_TARGET) random_word();

        wait_for_answers();
        repeat (100) @(posedge i_clk);

        $display("%0d result words checked: %0d done, %0d duplicate, %0d rejected, %0d pool full",
                 mirror.n_checked, mirror.n_stored, mirror.n_dup, mirror.n_reject, mirror.n_full);
        $display("%0d lookup hits, %0d of %0d nodes allocated, %0d long receiver hold-off(s)",
                 mirror.n_hits, mirror.next_free, NODE_COUNT, long_holds);
        if (mirror.fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit, several times the slowest expected run
    initial begin
        #4_000_000;
        $error("run limit reached with %0d result words outstanding", mirror.awaited.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
